FILE: rtl/bdx_pkg.sv
// bdx_pkg: shared sizes, codes and types for the binary boundary extract unit
// no dependencies; imported by the result and configuration interfaces and every module of the unit
`default_nettype none

package bdx_pkg;

  // frame limits
  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 1024;

  localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W  = $clog2(MAX_HEIGHT);
  localparam int unsigned WDIM_W = COL_W + 1;
  localparam int unsigned HDIM_W = ROW_W + 1;

  // port field widths
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned IDX_OUT_W  = 10;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  // result queue
  localparam int unsigned RES_SLOTS = 3;
  localparam int unsigned RES_N_W   = 2;
  localparam int unsigned RES_DEPTH = 4;
  localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);
  localparam int unsigned RES_CNT_W = RES_PTR_W + 1;

  // one line store entry: column pixel of the row above and the row before that
  typedef struct packed {
    logic prev_prev;
    logic prev;
  } bdx_line_t;

  // everything known about a pixel at the beat it is taken
  typedef struct packed {
    logic             pixel;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last_row;
    logic             last_col;
    logic             left1;
    logic             left2;
    logic             above;
    logic             above2;
    logic             above_l;
  } bdx_item_t;

  // one result beat
  typedef struct packed {
    logic [IDX_OUT_W-1:0] row_index;
    logic [IDX_OUT_W-1:0] col_index;
    logic                 is_edge;
    logic                 run_last;
    logic                 frame_done;
  } bdx_res_t;

endpackage

`default_nettype wire

FILE: rtl/bdx_if.sv
// bdx_if: valid/ready channels of the binary boundary extract unit
// depends on bdx_pkg for field widths
`default_nettype none

// pixel input channel
interface bdx_pix_if;
  logic valid;
  logic ready;
  logic pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

// result output channel
interface bdx_res_if;
  import bdx_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [IDX_OUT_W-1:0] row_index;
  logic [IDX_OUT_W-1:0] col_index;
  logic                 is_edge;
  logic                 run_last;
  logic                 frame_done;

  modport source (output valid, output row_index, output col_index, output is_edge,
                  output run_last, output frame_done, input ready);
  modport sink   (input valid, input row_index, input col_index, input is_edge,
                  input run_last, input frame_done, output ready);
endinterface

// configuration write channel
interface bdx_cfg_if;
  import bdx_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/bdx_line_store.sv
// bdx_line_store: two-row pixel history, one entry per column, registered read
// depends on bdx_pkg for the entry type and column width
`default_nettype none

module bdx_line_store (
  input  wire logic                    clk_i,
  input  wire logic                    acc_i,
  input  wire logic [bdx_pkg::COL_W-1:0] wr_addr_i,
  input  wire bdx_pkg::bdx_line_t      wr_data_i,
  input  wire logic [bdx_pkg::COL_W-1:0] rd_addr_i,
  output bdx_pkg::bdx_line_t           rd_data_o
);
  import bdx_pkg::*;

  bdx_line_t mem [MAX_WIDTH];
  bdx_line_t ram_q;
  bdx_line_t byp_data_q;
  logic      byp_q;

  // write the current column, fetch the next one; same address bypasses
  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      mem[wr_addr_i] <= wr_data_i;
      ram_q          <= mem[rd_addr_i];
      byp_q          <= (wr_addr_i == rd_addr_i);
      byp_data_q     <= wr_data_i;
    end
  end

  assign rd_data_o = byp_q ? byp_data_q : ram_q;

endmodule

`default_nettype wire

FILE: rtl/bdx_scan.sv
// bdx_scan: frame size registers, raster position, left window and line store addressing
// depends on bdx_pkg and the bdx_pix_if / bdx_cfg_if channels
`default_nettype none

module bdx_scan (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  bdx_pix_if.sink                        pix,
  bdx_cfg_if.sink                        cfg,
  input  wire logic                      stage_free_i,
  input  wire bdx_pkg::bdx_line_t        line_rd_i,
  output logic                           pix_acc_o,
  output bdx_pkg::bdx_item_t             item_o,
  output logic [bdx_pkg::COL_W-1:0]      wr_addr_o,
  output bdx_pkg::bdx_line_t             wr_data_o,
  output logic [bdx_pkg::COL_W-1:0]      rd_addr_o
);
  import bdx_pkg::*;

  logic [WDIM_W-1:0] width_q;
  logic [HDIM_W-1:0] height_q;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [1:0]        win_q, win_d;
  logic              above_prev_q;
  logic [WDIM_W-1:0] col_inc;
  logic [HDIM_W-1:0] row_inc;
  logic              last_col;
  logic              last_row;

  // zero acts as one, anything past the limit as the limit
  function automatic logic [WDIM_W-1:0] clamp_width(logic [CFG_DATA_W-1:0] v);
    logic [WDIM_W-1:0] res;
    if (v == '0) begin
      res = WDIM_W'(1);
    end else if (32'(v) > 32'(MAX_WIDTH)) begin
      res = WDIM_W'(MAX_WIDTH);
    end else begin
      res = WDIM_W'(v);
    end
    return res;
  endfunction

  function automatic logic [HDIM_W-1:0] clamp_height(logic [CFG_DATA_W-1:0] v);
    logic [HDIM_W-1:0] res;
    if (v == '0) begin
      res = HDIM_W'(1);
    end else if (32'(v) > 32'(MAX_HEIGHT)) begin
      res = HDIM_W'(MAX_HEIGHT);
    end else begin
      res = HDIM_W'(v);
    end
    return res;
  endfunction

  // handshakes
  assign cfg.ready  = 1'b1;
  assign pix.ready  = stage_free_i;
  assign pix_acc_o  = pix.valid & stage_free_i;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WDIM_W'(1);
      height_q <= HDIM_W'(1);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_IMAGE_WIDTH:  width_q  <= clamp_width(cfg.data);
        REG_IMAGE_HEIGHT: height_q <= clamp_height(cfg.data);
        default: ;
      endcase
    end
  end

  // row and column ends
  assign col_inc  = {1'b0, col_q} + WDIM_W'(1);
  assign row_inc  = {1'b0, row_q} + HDIM_W'(1);
  assign last_col = (col_inc >= width_q);
  assign last_row = (row_inc >= height_q);

  // line store: current column gets {above, pixel}, next column is fetched
  assign wr_addr_o           = col_q;
  assign wr_data_o.prev_prev = line_rd_i.prev;
  assign wr_data_o.prev      = pix.pixel;
  assign rd_addr_o           = last_col ? '0 : col_inc[COL_W-1:0];

  // item handed to the classify stage
  always_comb begin
    item_o.pixel    = pix.pixel;
    item_o.row      = row_q;
    item_o.col      = col_q;
    item_o.last_row = last_row;
    item_o.last_col = last_col;
    item_o.left1    = win_q[0];
    item_o.left2    = win_q[1];
    item_o.above    = line_rd_i.prev;
    item_o.above2   = line_rd_i.prev_prev;
    item_o.above_l  = above_prev_q;
  end

  // next raster position
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    win_d = win_q;
    if (pix_acc_o) begin
      if (last_col) begin
        col_d = '0;
        win_d = '0;
        row_d = last_row ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_d = col_inc[COL_W-1:0];
        win_d = {win_q[0], pix.pixel};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      win_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      win_q <= win_d;
    end
  end

  // above value of the previous column, i.e. row above at column minus one
  always_ff @(posedge clk_i) begin
    if (pix_acc_o) begin
      above_prev_q <= line_rd_i.prev;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bdx_classify.sv
// bdx_classify: second stage, decides edge for up to three pixels per beat
// depends on bdx_pkg; feeds bdx_res_fifo
`default_nettype none

module bdx_classify (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire logic                                      pix_acc_i,
  input  wire bdx_pkg::bdx_item_t                        item_i,
  input  wire bdx_pkg::bdx_line_t                        line_rd_i,
  input  wire logic [bdx_pkg::RES_CNT_W-1:0]             fifo_free_i,
  output logic                                           stage_free_o,
  output logic [bdx_pkg::RES_N_W-1:0]                    push_n_o,
  output bdx_pkg::bdx_res_t [bdx_pkg::RES_SLOTS-1:0]     push_data_o
);
  import bdx_pkg::*;

  bdx_item_t                   s1_q;
  logic                        s1_valid_q;
  logic                        advance;
  logic                        right;
  logic                        has_up, has_up2, has_left, has_left2;
  logic [ROW_W-1:0]            row_up;
  logic [RES_SLOTS-1:0]        cand_v;
  bdx_res_t [RES_SLOTS-1:0]    cand;
  bdx_res_t [RES_SLOTS-1:0]    slot;
  logic [RES_N_W-1:0]          n;

  function automatic logic [IDX_OUT_W-1:0] row_out(logic [ROW_W-1:0] v);
    logic [IDX_OUT_W+ROW_W-1:0] t;
    t = {{IDX_OUT_W{1'b0}}, v};
    return t[IDX_OUT_W-1:0];
  endfunction

  function automatic logic [IDX_OUT_W-1:0] col_out(logic [COL_W-1:0] v);
    logic [IDX_OUT_W+COL_W-1:0] t;
    t = {{IDX_OUT_W{1'b0}}, v};
    return t[IDX_OUT_W-1:0];
  endfunction

  // stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (pix_acc_i) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_acc_i) begin
      s1_q <= item_i;
    end
  end

  // neighbours inside the frame; line store now holds the next column
  assign right     = line_rd_i.prev;
  assign has_up    = (s1_q.row != '0);
  assign has_up2   = (s1_q.row > ROW_W'(1));
  assign has_left  = (s1_q.col != '0);
  assign has_left2 = (s1_q.col > COL_W'(1));
  assign row_up    = s1_q.row - ROW_W'(1);

  // candidate results: pixel above, left neighbour, the pixel itself
  always_comb begin
    cand_v[0]          = has_up;
    cand[0].row_index  = row_out(row_up);
    cand[0].col_index  = col_out(s1_q.col);
    cand[0].is_edge    = s1_q.above & ((has_up2 & ~s1_q.above2) | ~s1_q.pixel |
                                       (has_left & ~s1_q.above_l) |
                                       (~s1_q.last_col & ~right));
    cand[0].frame_done = 1'b0;

    cand_v[1]          = s1_q.last_row & has_left;
    cand[1].row_index  = row_out(s1_q.row);
    cand[1].col_index  = col_out(s1_q.col - COL_W'(1));
    cand[1].is_edge    = s1_q.left1 & ((has_up & ~s1_q.above_l) |
                                       (has_left2 & ~s1_q.left2) | ~s1_q.pixel);
    cand[1].frame_done = 1'b0;

    cand_v[2]          = s1_q.last_row & s1_q.last_col;
    cand[2].row_index  = row_out(s1_q.row);
    cand[2].col_index  = col_out(s1_q.col);
    cand[2].is_edge    = s1_q.pixel & ((has_up & ~s1_q.above) | (has_left & ~s1_q.left1));
    cand[2].frame_done = 1'b1;

    cand[0].run_last   = ~cand_v[1] & ~cand_v[2];
    cand[1].run_last   = ~cand_v[2];
    cand[2].run_last   = 1'b1;
  end

  // pack the valid candidates in order
  always_comb begin
    slot = '0;
    n    = '0;
    for (int k = 0; k < RES_SLOTS; k++) begin
      if (cand_v[k]) begin
        slot[n] = cand[k];
        n       = n + RES_N_W'(1);
      end
    end
  end

  // move on once the queue has room for every result of this beat
  assign advance      = s1_valid_q & (RES_CNT_W'(n) <= fifo_free_i);
  assign stage_free_o = ~s1_valid_q | advance;
  assign push_n_o     = advance ? n : '0;
  assign push_data_o  = slot;

endmodule

`default_nettype wire

FILE: rtl/bdx_res_fifo.sv
// bdx_res_fifo: small result queue, takes up to three beats a cycle, gives one
// depends on bdx_pkg and the bdx_res_if channel
`default_nettype none

module bdx_res_fifo (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic [bdx_pkg::RES_N_W-1:0]            push_n_i,
  input  wire bdx_pkg::bdx_res_t [bdx_pkg::RES_SLOTS-1:0] push_data_i,
  output logic [bdx_pkg::RES_CNT_W-1:0]               free_o,
  bdx_res_if.source                                   res
);
  import bdx_pkg::*;

  bdx_res_t             buf_q [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr_q;
  logic [RES_PTR_W-1:0] rd_ptr_q;
  logic [RES_CNT_W-1:0] cnt_q;
  logic                 pop;
  bdx_res_t             head;

  assign pop    = res.valid & res.ready;
  assign free_o = RES_CNT_W'(RES_DEPTH) - cnt_q;

  // queue storage
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < RES_SLOTS; k++) begin
      if (RES_N_W'(k) < push_n_i) begin
        buf_q[wr_ptr_q + RES_PTR_W'(k)] <= push_data_i[k];
      end
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + RES_PTR_W'(push_n_i);
      rd_ptr_q <= rd_ptr_q + RES_PTR_W'(pop);
      cnt_q    <= cnt_q + RES_CNT_W'(push_n_i) - RES_CNT_W'(pop);
    end
  end

  // head beat
  assign head           = buf_q[rd_ptr_q];
  assign res.valid      = (cnt_q != '0);
  assign res.row_index  = head.row_index;
  assign res.col_index  = head.col_index;
  assign res.is_edge    = head.is_edge;
  assign res.run_last   = head.run_last;
  assign res.frame_done = head.frame_done;

endmodule

`default_nettype wire

FILE: rtl/binary_boundary_extract_unit.sv
// binary_boundary_extract_unit: top level, 4-neighbour boundary marking of binary frames
// depends on bdx_pkg, bdx_if, bdx_line_store, bdx_scan, bdx_classify, bdx_res_fifo
//
//   channel   | dir | handshake    | payload
//   ----------+-----+--------------+-------------------------------------------------
//   pixel_i   | in  | valid/ready  | pixel
//   result_o  | out | valid/ready  | row_index, col_index, is_edge, run_last, frame_done
//   cfg_i     | in  | valid/ready  | index (0 width, 1 height), data
//
// one pixel a cycle while the classify stage is free; its results pass the classify stage register, then the queue.
// final-row pixels cause up to three results, so there the input follows the output rate.
// the line store is one 2-bit entry per column, written and fetched once per pixel.
// reset clears position and frame size to 1x1; line store contents are not cleared.
// a stalled output fills a four-beat queue, then holds the classify stage and input.
`default_nettype none

module binary_boundary_extract_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bdx_pix_if.sink   pixel_i,
  bdx_res_if.source result_o,
  bdx_cfg_if.sink   cfg_i
);
  import bdx_pkg::*;

  logic                          pix_acc;
  logic                          stage_free;
  bdx_item_t                     item;
  logic [COL_W-1:0]              wr_addr;
  logic [COL_W-1:0]              rd_addr;
  bdx_line_t                     wr_data;
  bdx_line_t                     line_rd;
  logic [RES_CNT_W-1:0]          fifo_free;
  logic [RES_N_W-1:0]            push_n;
  bdx_res_t [RES_SLOTS-1:0]      push_data;

  // raster position and configuration
  bdx_scan u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pix          (pixel_i),
    .cfg          (cfg_i),
    .stage_free_i (stage_free),
    .line_rd_i    (line_rd),
    .pix_acc_o    (pix_acc),
    .item_o       (item),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data),
    .rd_addr_o    (rd_addr)
  );

  // two-row history
  bdx_line_store u_line (
    .clk_i     (clk_i),
    .acc_i     (pix_acc),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (line_rd)
  );

  // edge decisions
  bdx_classify u_classify (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pix_acc_i    (pix_acc),
    .item_i       (item),
    .line_rd_i    (line_rd),
    .fifo_free_i  (fifo_free),
    .stage_free_o (stage_free),
    .push_n_o     (push_n),
    .push_data_o  (push_data)
  );

  // result queue
  bdx_res_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_n_i    (push_n),
    .push_data_i (push_data),
    .free_o      (fifo_free),
    .res         (result_o)
  );

endmodule

`default_nettype wire

FILE: tb/tb.sv
// tb: self-checking bench for binary_boundary_extract_unit, 4-neighbour edge marking
// depends on bdx_pkg, bdx_if and the unit; random raster frames checked beat by beat
`default_nettype none

module tb;
  import bdx_pkg::*;

  // index codes outside the register map, written to cover the upper index bit
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);

  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned RANDOM_PIXELS = 130;
  localparam int unsigned EDGE_RUN      = 48;

  logic clk_i;
  logic rst_ni;

  bdx_pix_if pix_if ();
  bdx_res_if res_if ();
  bdx_cfg_if cfg_if ();

  binary_boundary_extract_unit u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .pixel_i  (pix_if),
    .result_o (res_if),
    .cfg_i    (cfg_if)
  );

  // pending pixels and outstanding edge results
  bit          pixel_q[$];
  bdx_res_t    edge_results_q[$];
  int unsigned pixels_queued  = 0;
  int unsigned pixels_taken   = 0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned src_idle_pct   = 28;
  int unsigned snk_idle_pct   = 28;
  bit          hold_req       = 1'b0;
  bit          hold_used;
  int unsigned hold_left;

  // scan state of the edge predictor
  bit          row_above[MAX_WIDTH];
  bit          row_above2[MAX_WIDTH];
  int unsigned scan_row = 0;
  int unsigned scan_col = 0;
  bit [3:0]    left_bits = '0;
  int unsigned frame_w = 1;
  int unsigned frame_h = 1;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic int unsigned fit_dim(logic [CFG_DATA_W-1:0] v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  function automatic bit boundary_bit(bit center, bit has_up, bit up, bit has_dn, bit dn,
                                      bit has_lf, bit lf, bit has_rt, bit rt);
    return center & ((has_up & ~up) | (has_dn & ~dn) | (has_lf & ~lf) | (has_rt & ~rt));
  endfunction

  function automatic bdx_res_t result_beat(int unsigned row, int unsigned col, bit is_edge,
                                           bit done);
    bdx_res_t b;
    b.row_index  = IDX_OUT_W'(row);
    b.col_index  = IDX_OUT_W'(col);
    b.is_edge    = is_edge;
    b.run_last   = 1'b0;
    b.frame_done = done;
    return b;
  endfunction

  // expected results for one accepted pixel, then advance the scan position
  task automatic predict_boundary(bit px);
    int unsigned r, c, n;
    bit          last_row, last_col, up, up2, up_l, up_r;
    bdx_res_t    beats[3];
    r        = scan_row;
    c        = scan_col;
    n        = 0;
    last_row = (r + 1 >= frame_h);
    last_col = (c + 1 >= frame_w);
    up       = row_above[c];
    up2      = row_above2[c];
    up_l     = (c > 0) ? row_above2[c - 1] : 1'b0;
    up_r     = (c + 1 < frame_w) ? row_above[c + 1] : 1'b0;
    // pixel above is complete once the one below arrives
    if (r >= 1) begin
      beats[n] = result_beat(r - 1, c, boundary_bit(up, r >= 2, up2, 1'b1, px, c > 0, up_l,
                                                    c + 1 < frame_w, up_r), 1'b0);
      n++;
    end
    // final row: left neighbour now has its right side
    if (last_row && c >= 1) begin
      beats[n] = result_beat(r, c - 1, boundary_bit(left_bits[0], r >= 1, up_l, 1'b0, 1'b0,
                                                    c >= 2, left_bits[1], 1'b1, px), 1'b0);
      n++;
    end
    // last pixel of the frame reports itself
    if (last_row && last_col) begin
      beats[n] = result_beat(r, c, boundary_bit(px, r >= 1, up, 1'b0, 1'b0, c >= 1,
                                                left_bits[0], 1'b0, 1'b0), 1'b1);
      n++;
    end
    if (n > 0) beats[n - 1].run_last = 1'b1;
    for (int i = 0; i < n; i++) edge_results_q.push_back(beats[i]);

    row_above2[c] = up;
    row_above[c]  = px;
    left_bits     = {left_bits[2:0], px};
    if (last_col) begin
      scan_col  = 0;
      left_bits = '0;
      scan_row  = last_row ? 0 : r + 1;
    end else begin
      scan_col = c + 1;
    end
  endtask

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, int unsigned got, int unsigned want);
    if (got != want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  task automatic check_result(bdx_res_t got);
    bdx_res_t want;
    if (edge_results_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result row %0d col %0d", got.row_index,
                                got.col_index));
      return;
    end
    want = edge_results_q.pop_front();
    check_field("row_index", 32'(got.row_index), 32'(want.row_index));
    check_field("col_index", 32'(got.col_index), 32'(want.col_index));
    check_field("is_edge", 32'(got.is_edge), 32'(want.is_edge));
    check_field("run_last", 32'(got.run_last), 32'(want.run_last));
    check_field("frame_done", 32'(got.frame_done), 32'(want.frame_done));
  endtask

  // pixel driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_if.valid <= 1'b0;
      pix_if.pixel <= 1'b0;
    end else if (!pix_if.valid || pix_if.ready) begin
      if (pixel_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        pix_if.valid <= 1'b1;
        pix_if.pixel <= pixel_q.pop_front();
      end else begin
        pix_if.valid <= 1'b0;
      end
    end
  end

  // result ready, with one long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      hold_used    <= 1'b0;
      hold_left    <= 0;
    end else if (hold_req && !hold_used) begin
      hold_used    <= 1'b1;
      hold_left    <= HOLD_CYCLES;
      res_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // monitor: check result beats, predict on pixel beats, track register writes
  always @(posedge clk_i) begin : monitor
    bdx_res_t beat;
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        beat.row_index  = res_if.row_index;
        beat.col_index  = res_if.col_index;
        beat.is_edge    = res_if.is_edge;
        beat.run_last   = res_if.run_last;
        beat.frame_done = res_if.frame_done;
        check_result(beat);
      end
      if (pix_if.valid && pix_if.ready) begin
        predict_boundary(pix_if.pixel);
        pixels_taken++;
      end
      if (cfg_if.valid && cfg_if.ready) begin
        if (cfg_if.index == REG_IMAGE_WIDTH) frame_w = fit_dim(cfg_if.data, MAX_WIDTH);
        else if (cfg_if.index == REG_IMAGE_HEIGHT) frame_h = fit_dim(cfg_if.data, MAX_HEIGHT);
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin
    if (!rst_ni || (pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_pattern(logic [31:0] bits, int unsigned n);
    for (int i = n - 1; i >= 0; i--) begin
      pixel_q.push_back(bits[i]);
      pixels_queued++;
    end
  endtask

  task automatic push_random(int unsigned n, int unsigned density);
    for (int unsigned i = 0; i < n; i++) begin
      pixel_q.push_back($urandom_range(99) < density);
      pixels_queued++;
    end
  endtask

  // all pixels taken, all results back, then let the pipeline settle
  task automatic wait_drained();
    while (pixels_taken != pixels_queued || edge_results_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_frame(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h);
    wait_drained();
    cfg_write(REG_IMAGE_WIDTH, w);
    cfg_write(REG_IMAGE_HEIGHT, h);
  endtask

  // stimulus and end of run
  initial begin : stimulus
    int unsigned random_count, w, h, frames, density, remaining;
    rst_ni        = 1'b0;
    pix_if.valid  = 1'b0;
    pix_if.pixel  = 1'b0;
    res_if.ready  = 1'b0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = '0;
    cfg_if.data   = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // 1x1 frames at the reset size
    push_pattern(32'b10, 2);
    wait_drained();

    // zero sizes act as one; unmapped indexes are ignored
    cfg_write(REG_IMAGE_WIDTH, '0);
    cfg_write(REG_IMAGE_HEIGHT, '0);
    cfg_write(REG_SPARE_2, '1);
    cfg_write(REG_SPARE_3, '0);
    push_pattern(32'b1, 1);

    // 3x3 frame with mixed content
    set_frame(3, 3);
    push_pattern(32'b110_111_011, 9);

    // height lowered below the current row mid-frame: this row becomes final
    set_frame(3, 4);
    push_pattern(32'b111_101, 6);
    wait_drained();
    cfg_write(REG_IMAGE_HEIGHT, 1);
    push_pattern(32'b111, 3);

    // width lowered below the current column mid-row: the row ends at once
    set_frame(3, 2);
    push_pattern(32'b011_10, 5);
    wait_drained();
    cfg_write(REG_IMAGE_WIDTH, 1);
    push_pattern(32'b1, 1);

    // sizes above the limit clamp: a long run into a wide row, ended by a narrower width
    set_frame('1, 1);
    push_random(EDGE_RUN, 70);
    wait_drained();
    cfg_write(REG_IMAGE_WIDTH, 1);
    push_pattern(32'b1, 1);

    // same down a tall single column, ended by a lower height
    set_frame(1, 1500);
    push_random(EDGE_RUN, 70);
    wait_drained();
    cfg_write(REG_IMAGE_HEIGHT, 1);
    push_pattern(32'b1, 1);

    // no idling, output held off long enough to back up the input
    set_frame(16, 4);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_req     = 1'b1;
    push_random(64, 50);
    wait_drained();
    src_idle_pct = 28;
    snk_idle_pct = 28;

    // random frames, mostly narrow
    random_count = 0;
    while (random_count < RANDOM_PIXELS) begin
      w       = ($urandom_range(9) < 7) ? $urandom_range(1, 8) : $urandom_range(9, 40);
      h       = $urandom_range(1, 6);
      frames  = $urandom_range(1, 3);
      density = ($urandom_range(2) == 0) ? 15 : (($urandom_range(1) == 0) ? 50 : 85);
      // keep the total within the pixel budget
      remaining = RANDOM_PIXELS - random_count;
      if (w > remaining) w = remaining;
      if (w * h > remaining) h = remaining / w;
      if (w * h * frames > remaining) frames = 1;
      set_frame(CFG_DATA_W'(w), CFG_DATA_W'(h));
      push_random(w * h * frames, density);
      random_count += w * h * frames;
    end

    wait_drained();
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: binary_boundary_extract_unit.f
rtl/bdx_pkg.sv
rtl/bdx_if.sv
rtl/bdx_line_store.sv
rtl/bdx_scan.sv
rtl/bdx_classify.sv
rtl/bdx_res_fifo.sv
rtl/binary_boundary_extract_unit.sv
tb/tb.sv
